// ----- hdl/pes_pkg.sv -----
// pes_pkg: types and constants shared by the pointer event synthesizer modules.
// No dependencies.
`timescale 1ns / 1ps

package pes_pkg;

  localparam int NUM_SOURCES = 4;
  localparam int NUM_BUTTONS = 3;
  localparam int CNT_W       = $clog2(NUM_SOURCES + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [NUM_BUTTONS-1:0] BUTTON_MASK = 3'h7;

  // Operation codes of an input report
  localparam logic [1:0] OP_RELATIVE = 2'd0;
  localparam logic [1:0] OP_ABSOLUTE = 2'd1;
  localparam logic [1:0] OP_RELEASE  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic [11:0] LIMIT_X_RST  = 12'd1023;
  localparam logic [11:0] LIMIT_Y_RST  = 12'd767;
  localparam logic [11:0] CURSOR_X_RST = 12'd512;
  localparam logic [11:0] CURSOR_Y_RST = 12'd384;

  // Event slots of one planned report, in emission order
  localparam int SLOT_MOVE   = 0;
  localparam int SLOT_BTN0   = 1;
  localparam int SLOT_WHEEL  = NUM_BUTTONS + 1;
  localparam int NUM_SLOTS   = NUM_BUTTONS + 2;

  typedef enum logic [1:0] {
    KIND_MOVE  = 2'd0,
    KIND_DOWN  = 2'd1,
    KIND_UP    = 2'd2,
    KIND_WHEEL = 2'd3
  } pes_kind_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         source;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [2:0]         button_bits;
    logic signed [15:0] wheel;
    logic               wheel_to_text;
    logic [7:0]         modifier_keys;
    logic [31:0]        timestamp;
  } pes_in_t;

  typedef struct packed {
    pes_kind_e          event_kind;
    logic [11:0]        cursor_x;
    logic [11:0]        cursor_y;
    logic signed [15:0] event_dx;
    logic signed [15:0] event_dy;
    logic [2:0]         held_buttons;
    logic [1:0]         button_index;
    logic [7:0]         event_modifiers;
    logic [31:0]        event_tick;
    logic               last;
  } pes_out_t;

  // One classified report waiting for expansion into events
  typedef struct packed {
    logic [NUM_SLOTS-1:0]   slots;
    logic [11:0]            cursor_x;
    logic [11:0]            cursor_y;
    logic signed [15:0]     dx;
    logic signed [15:0]     dy;
    logic signed [15:0]     wheel;
    logic [NUM_BUTTONS-1:0] held;
    logic [7:0]             mods;
    logic [31:0]            tick;
  } pes_plan_t;

endpackage

// ----- hdl/pointer_event_synthesizer_core.sv -----
// pointer_event_synthesizer_core: top level, front classifier, plan queue and
// event expander. Depends on pes_pkg, pes_front, pes_queue, pes_back.
`timescale 1ns / 1ps

// A report is taken whenever the queue is not full: the front updates cursor and
// button state at once and queues a plan of up to five events in a four-entry
// queue, so reports may arrive on every cycle while the queue has room. The back
// end sends one event per cycle while the output is not stalled, through a
// registered output; sustained throughput is set by the output channel. A plan is
// written into the queue and its first event then into the output register.
// Reports that yield no events (disabled, undefined operation, or no motion,
// button change or wheel) are taken and produce nothing.
module pointer_event_synthesizer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [12:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pes_pkg::pes_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pes_pkg::pes_out_t out_data_o
);
  import pes_pkg::*;

  pes_plan_t plan, head;
  logic      push, pop, full, empty;

  pes_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .plan_o      (plan),
    .full_i      (full)
  );

  pes_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (plan),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  pes_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hdl/pes_front.sv -----
// pes_front: accepts reports, keeps cursor, button and config state, and builds
// an event plan per report. Depends on pes_pkg.
`timescale 1ns / 1ps

module pes_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [12:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pes_pkg::pes_in_t  in_data_i,
  output logic              push_o,
  output pes_pkg::pes_plan_t plan_o,
  input  logic              full_i
);
  import pes_pkg::*;

  logic                   enable_q;
  logic [11:0]            limit_x_q, limit_y_q;
  logic [11:0]            cursor_x_q, cursor_y_q;
  logic [11:0]            cursor_x_d, cursor_y_d;
  logic [CNT_W-1:0]       cnt_q [NUM_BUTTONS];
  logic [CNT_W-1:0]       cnt_d [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] src_btn_q [NUM_SOURCES];

  logic                   accept, go, op_ok, src_ok, move, wheel_ev;
  logic [NUM_BUTTONS-1:0] old_btn, new_btn, held_before, held_after, changed;
  logic signed [17:0]     sum_x, sum_y;
  logic [11:0]            new_x, new_y;
  logic signed [15:0]     dx, dy;

  // Effective size is 1..4096; keep only the largest coordinate
  function automatic logic [11:0] size_limit(logic [12:0] s);
    logic [12:0] tmp;
    tmp = s - 13'd1;
    if (s == 13'd0) return 12'd0;
    else if (s > 13'd4096) return 12'd4095;
    else return tmp[11:0];
  endfunction

  function automatic logic [11:0] clamp_rel(logic signed [17:0] v, logic [11:0] lim);
    if (v < 18'sd0) return 12'd0;
    else if (v > $signed({6'd0, lim})) return lim;
    else return v[11:0];
  endfunction

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign op_ok      = (in_data_i.operation == OP_RELATIVE) ||
                      (in_data_i.operation == OP_ABSOLUTE) ||
                      (in_data_i.operation == OP_RELEASE);
  assign src_ok     = 32'(in_data_i.source) < NUM_SOURCES;
  assign go         = accept && enable_q && op_ok && src_ok;

  assign old_btn = src_btn_q[in_data_i.source];
  assign new_btn = (in_data_i.operation == OP_RELEASE) ? '0
                                                       : (in_data_i.button_bits & BUTTON_MASK);

  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      held_before[b] = cnt_q[b] != '0;
      cnt_d[b] = cnt_q[b];
      if (new_btn[b] && !old_btn[b]) cnt_d[b] = cnt_q[b] + CNT_W'(1);
      else if (!new_btn[b] && old_btn[b]) cnt_d[b] = cnt_q[b] - CNT_W'(1);
      held_after[b] = cnt_d[b] != '0;
    end
  end
  assign changed = held_before ^ held_after;

  assign sum_x = $signed({6'd0, cursor_x_q}) + 18'($signed(in_data_i.delta_x));
  assign sum_y = $signed({6'd0, cursor_y_q}) + 18'($signed(in_data_i.delta_y));

  always_comb begin
    move  = 1'b0;
    dx    = '0;
    dy    = '0;
    new_x = cursor_x_q;
    new_y = cursor_y_q;
    unique case (in_data_i.operation)
      OP_RELATIVE: begin
        move  = (in_data_i.delta_x != '0) || (in_data_i.delta_y != '0);
        dx    = in_data_i.delta_x;
        dy    = in_data_i.delta_y;
        new_x = clamp_rel(sum_x, limit_x_q);
        new_y = clamp_rel(sum_y, limit_y_q);
      end
      OP_ABSOLUTE: begin
        // motion is position minus cursor; the new cursor is the position, clamped to the limit
        move  = (in_data_i.pos_x != {4'd0, cursor_x_q}) ||
                (in_data_i.pos_y != {4'd0, cursor_y_q});
        dx    = $signed(in_data_i.pos_x - {4'd0, cursor_x_q});
        dy    = $signed(in_data_i.pos_y - {4'd0, cursor_y_q});
        new_x = (in_data_i.pos_x > {4'd0, limit_x_q}) ? limit_x_q : in_data_i.pos_x[11:0];
        new_y = (in_data_i.pos_y > {4'd0, limit_y_q}) ? limit_y_q : in_data_i.pos_y[11:0];
      end
      default: begin
      end
    endcase
  end

  assign cursor_x_d = move ? new_x : cursor_x_q;
  assign cursor_y_d = move ? new_y : cursor_y_q;
  assign wheel_ev   = (in_data_i.operation == OP_RELATIVE) && (in_data_i.wheel != '0) &&
                      !in_data_i.wheel_to_text;

  always_comb begin
    plan_o.slots                                 = '0;
    plan_o.slots[SLOT_MOVE]                      = move;
    plan_o.slots[SLOT_BTN0 +: NUM_BUTTONS]       = changed;
    plan_o.slots[SLOT_WHEEL]                     = wheel_ev;
    plan_o.cursor_x                              = cursor_x_d;
    plan_o.cursor_y                              = cursor_y_d;
    plan_o.dx                                    = dx;
    plan_o.dy                                    = dy;
    plan_o.wheel                                 = in_data_i.wheel;
    plan_o.held                                  = held_after;
    plan_o.mods                                  = in_data_i.modifier_keys;
    plan_o.tick                                  = in_data_i.timestamp;
  end

  assign push_o = go && (move || (changed != '0) || wheel_ev);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      limit_x_q  <= LIMIT_X_RST;
      limit_y_q  <= LIMIT_Y_RST;
      cursor_x_q <= CURSOR_X_RST;
      cursor_y_q <= CURSOR_Y_RST;
      for (int b = 0; b < NUM_BUTTONS; b++) cnt_q[b] <= '0;
      for (int s = 0; s < NUM_SOURCES; s++) src_btn_q[s] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ENABLE: enable_q  <= cfg_data_i[0];
          CFG_WIDTH:  limit_x_q <= size_limit(cfg_data_i);
          CFG_HEIGHT: limit_y_q <= size_limit(cfg_data_i);
          default: begin
          end
        endcase
      end
      if (go) begin
        cursor_x_q                   <= cursor_x_d;
        cursor_y_q                   <= cursor_y_d;
        cnt_q                        <= cnt_d;
        src_btn_q[in_data_i.source] <= new_btn;
      end
    end
  end

endmodule

// ----- hdl/pes_queue.sv -----
// pes_queue: small FIFO of event plans between front and back.
// Depends on pes_pkg.
`timescale 1ns / 1ps

module pes_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pes_pkg::pes_plan_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output pes_pkg::pes_plan_t head_o,
  output logic               empty_o
);
  import pes_pkg::*;

  pes_plan_t         entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_i && !pop_i)      count_q <= count_q + (QPTR_W+1)'(1);
      else if (!push_i && pop_i) count_q <= count_q - (QPTR_W+1)'(1);
    end
  end

endmodule

// ----- hdl/pes_back.sv -----
// pes_back: expands the plan at the queue head into events, one per cycle while
// the output is not stalled, into the output register. Depends on pes_pkg.
`timescale 1ns / 1ps

module pes_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pes_pkg::pes_plan_t head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pes_pkg::pes_out_t  out_data_o
);
  import pes_pkg::*;

  logic [NUM_SLOTS-1:0] done_q;
  logic [NUM_SLOTS-1:0] pending, sel;
  logic                 out_valid_q, advance, fire;
  pes_out_t             out_q, ev;

  assign pending = head_i.slots & ~done_q;

  // lowest pending slot goes first: move, buttons in order, then wheel
  always_comb begin
    sel = '0;
    ev  = '0;
    ev.cursor_x        = head_i.cursor_x;
    ev.cursor_y        = head_i.cursor_y;
    ev.held_buttons    = head_i.held;
    ev.event_modifiers = head_i.mods;
    ev.event_tick      = head_i.tick;
    priority if (pending[SLOT_MOVE]) begin
      sel[SLOT_MOVE] = 1'b1;
      ev.event_kind  = KIND_MOVE;
      ev.event_dx    = head_i.dx;
      ev.event_dy    = head_i.dy;
    end else if (pending[SLOT_BTN0]) begin
      sel[SLOT_BTN0]  = 1'b1;
      ev.event_kind   = head_i.held[0] ? KIND_DOWN : KIND_UP;
      ev.button_index = 2'd0;
    end else if (pending[SLOT_BTN0+1]) begin
      sel[SLOT_BTN0+1] = 1'b1;
      ev.event_kind    = head_i.held[1] ? KIND_DOWN : KIND_UP;
      ev.button_index  = 2'd1;
    end else if (pending[SLOT_BTN0+2]) begin
      sel[SLOT_BTN0+2] = 1'b1;
      ev.event_kind    = head_i.held[2] ? KIND_DOWN : KIND_UP;
      ev.button_index  = 2'd2;
    end else begin
      sel[SLOT_WHEEL] = 1'b1;
      ev.event_kind   = KIND_WHEEL;
      ev.event_dy     = head_i.wheel;
    end
    ev.last = (pending & ~sel) == '0;
  end

  assign advance = !out_valid_q || !out_stall_i;
  assign fire    = advance && !empty_i;
  assign pop_o   = fire && ev.last;

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else begin
      if (advance) out_valid_q <= !empty_i;
      if (fire) begin
        if (ev.last) done_q <= '0;
        else         done_q <= done_q | sel;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sim/pointer_event_synthesizer_core_tb.sv -----
// pointer_event_synthesizer_core_tb: self-checking testbench for the pointer event core.
// Predicts the event stream of every accepted report and checks it field by field.
// Depends on pes_pkg and pointer_event_synthesizer_core.
`timescale 1ns / 1ps

module pointer_event_synthesizer_core_tb;
  import pes_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int MAX_PRINTS   = 100;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  pes_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  pes_out_t    out_data;

  pointer_event_synthesizer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pes_in_t  report_q[$];
  pes_out_t event_q[$];

  // shadow of the block's registers and pointer state
  logic        en_sh;
  logic [12:0] width_sh;
  logic [12:0] height_sh;
  logic [11:0] cur_x;
  logic [11:0] cur_y;
  int          holders[NUM_BUTTONS];
  logic [2:0]  src_btns[NUM_SOURCES];

  int err_cnt;
  int ev_cnt;
  int cycle_cnt;
  int gap_left;
  int stall_left;
  bit in_taken;
  bit steady_tx;
  bit steady_rx;
  bit hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int eff_size(logic [12:0] s);
    if (s == 13'd0) return 1;
    if (s > 13'd4096) return 4096;
    return int'(s);
  endfunction

  function automatic logic [11:0] clamp_axis(int v, int lim);
    if (v < 0) return 12'd0;
    if (v >= lim) return 12'(lim - 1);
    return 12'(v);
  endfunction

  function automatic logic [2:0] held_mask();
    logic [2:0] m;
    m = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) m[b] = (holders[b] != 0);
    return m;
  endfunction

  function automatic pes_out_t make_event(pes_kind_e kind, logic signed [15:0] dx,
                                          logic signed [15:0] dy, logic [2:0] held,
                                          logic [1:0] idx, pes_in_t r);
    pes_out_t e;
    e.event_kind      = kind;
    e.cursor_x        = cur_x;
    e.cursor_y        = cur_y;
    e.event_dx        = dx;
    e.event_dy        = dy;
    e.held_buttons    = held;
    e.button_index    = idx;
    e.event_modifiers = r.modifier_keys;
    e.event_tick      = r.timestamp;
    e.last            = 1'b0;
    return e;
  endfunction

  // Update pointer state for one report and queue the events it produces.
  function automatic void expand_report(pes_in_t r);
    int         dx;
    int         dy;
    int         n;
    logic [2:0] btns;
    logic [2:0] before_m;
    logic [2:0] after_m;
    logic [2:0] chg;
    pes_out_t   evs[NUM_SLOTS];
    if (!en_sh || r.operation == OP_UNUSED || int'(r.source) >= NUM_SOURCES) return;
    btns = r.button_bits;
    dx = 0;
    dy = 0;
    n = 0;
    case (r.operation)
      OP_RELATIVE: begin
        dx = int'(r.delta_x);
        dy = int'(r.delta_y);
      end
      OP_ABSOLUTE: begin
        dx = int'(r.pos_x) - int'(cur_x);
        dy = int'(r.pos_y) - int'(cur_y);
      end
      default: btns = '0;
    endcase
    before_m = held_mask();
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (btns[b] && !src_btns[r.source][b]) holders[b]++;
      else if (!btns[b] && src_btns[r.source][b]) holders[b]--;
    end
    src_btns[r.source] = btns;
    after_m = held_mask();
    // cursor only clamps when there is motion
    if (dx != 0 || dy != 0) begin
      cur_x = clamp_axis(int'(cur_x) + dx, eff_size(width_sh));
      cur_y = clamp_axis(int'(cur_y) + dy, eff_size(height_sh));
      evs[n] = make_event(KIND_MOVE, dx[15:0], dy[15:0], after_m, 2'd0, r);
      n++;
    end
    chg = after_m ^ before_m;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (chg[b]) begin
        if (after_m[b]) evs[n] = make_event(KIND_DOWN, '0, '0, after_m, 2'(b), r);
        else evs[n] = make_event(KIND_UP, '0, '0, after_m, 2'(b), r);
        n++;
      end
    end
    if (r.operation == OP_RELATIVE && r.wheel != '0 && !r.wheel_to_text) begin
      evs[n] = make_event(KIND_WHEEL, '0, r.wheel, after_m, 2'd0, r);
      n++;
    end
    if (n > 0) evs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) event_q.push_back(evs[i]);
  endfunction

  task automatic report_error(string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("event %0d %s got %h want %h", ev_cnt, name, got, want));
  endtask

  task automatic check_event(pes_out_t got);
    pes_out_t want;
    ev_cnt++;
    if (event_q.size() == 0) begin
      report_error($sformatf("event %0d arrived with none expected", ev_cnt));
      return;
    end
    want = event_q.pop_front();
    cmp_field("event_kind", 32'(got.event_kind), 32'(want.event_kind));
    cmp_field("cursor_x", 32'(got.cursor_x), 32'(want.cursor_x));
    cmp_field("cursor_y", 32'(got.cursor_y), 32'(want.cursor_y));
    cmp_field("event_dx", 32'(got.event_dx), 32'(want.event_dx));
    cmp_field("event_dy", 32'(got.event_dy), 32'(want.event_dy));
    cmp_field("held_buttons", 32'(got.held_buttons), 32'(want.held_buttons));
    cmp_field("button_index", 32'(got.button_index), 32'(want.button_index));
    cmp_field("event_modifiers", 32'(got.event_modifiers), 32'(want.event_modifiers));
    cmp_field("event_tick", got.event_tick, want.event_tick);
    cmp_field("last", 32'(got.last), 32'(want.last));
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic pes_in_t mk_report(logic [1:0] op, int src, int dx, int dy, int px, int py,
                                        int btn, int whl, bit txt, int mods,
                                        logic [31:0] tick);
    pes_in_t r;
    r.operation     = op;
    r.source        = 2'(src);
    r.delta_x       = 16'(dx);
    r.delta_y       = 16'(dy);
    r.pos_x         = 16'(px);
    r.pos_y         = 16'(py);
    r.button_bits   = 3'(btn);
    r.wheel         = 16'(whl);
    r.wheel_to_text = txt;
    r.modifier_keys = 8'(mods);
    r.timestamp     = tick;
    return r;
  endfunction

  function automatic pes_in_t rand_report(int w, int h);
    pes_in_t r;
    int      sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) r.operation = OP_RELATIVE;
    else if (sel < 75) r.operation = OP_ABSOLUTE;
    else if (sel < 93) r.operation = OP_RELEASE;
    else r.operation = OP_UNUSED;
    r.source = 2'($urandom_range(0, 3));
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      r.delta_x = '0;
      r.delta_y = '0;
    end else if (sel < 4) begin
      r.delta_x = 16'($urandom);
      r.delta_y = 16'($urandom);
    end else begin
      r.delta_x = 16'($urandom_range(0, 40) - 20);
      r.delta_y = 16'($urandom_range(0, 40) - 20);
    end
    if ($urandom_range(0, 4) == 0) begin
      r.pos_x = 16'($urandom);
      r.pos_y = 16'($urandom);
    end else begin
      r.pos_x = 16'($urandom_range(0, w + 8));
      r.pos_y = 16'($urandom_range(0, h + 8));
    end
    r.button_bits = 3'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 4) r.wheel = '0;
    else if (sel < 7) r.wheel = 16'($urandom_range(0, 10) - 5);
    else r.wheel = 16'($urandom);
    r.wheel_to_text = ($urandom_range(0, 3) == 0);
    r.modifier_keys = 8'($urandom);
    r.timestamp     = $urandom;
    return r;
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (in_valid && !in_stall) begin
        expand_report(in_data);
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) check_event(out_data);
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("[pointer_event_synthesizer_core] ERROR");
        $finish;
      end
    end
  end

  // report driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (report_q.size() > 0) begin
        in_data  <= report_q.pop_front();
        in_valid <= 1'b1;
        gap_left = pick_gap(steady_tx);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // event receiver: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!steady_rx && $urandom_range(0, 99) < 25) stall_left = pick_gap(1'b0);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ENABLE: en_sh = val[0];
      CFG_WIDTH:  width_sh = val;
      CFG_HEIGHT: height_sh = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // wait until every report is sent and every expected event has come out
  task automatic settle();
    while (report_q.size() != 0 || in_valid || event_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int p;
    int w;
    int h;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    en_sh     = 1'b0;
    width_sh  = 13'd1024;
    height_sh = 13'd768;
    cur_x     = CURSOR_X_RST;
    cur_y     = CURSOR_Y_RST;
    for (int b = 0; b < NUM_BUTTONS; b++) holders[b] = 0;
    for (int s = 0; s < NUM_SOURCES; s++) src_btns[s] = '0;
    err_cnt    = 0;
    ev_cnt     = 0;
    cycle_cnt  = 0;
    gap_left   = 0;
    stall_left = 0;
    in_taken   = 1'b0;
    steady_tx  = 1'b1;
    steady_rx  = 1'b0;
    hold_req   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // disabled after reset: nothing comes out and state stays put
    report_q.push_back(mk_report(OP_RELATIVE, 0, 100, -100, 0, 0, 7, 9, 0, 'hFF, 1));
    report_q.push_back(mk_report(OP_ABSOLUTE, 1, 0, 0, 5, 5, 3, 0, 0, 0, 2));
    report_q.push_back(mk_report(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3));
    settle();
    write_reg(CFG_ENABLE, 13'd1);

    report_q.push_back(mk_report(OP_RELATIVE, 0, 10, 5, 0, 0, 1, 0, 0, 'hFF, 32'hFFFF_FFFF));
    report_q.push_back(mk_report(OP_RELATIVE, 0, -32768, -32768, 0, 0, 0, 0, 0, 'h5A, 10));
    // five events: move, three downs, wheel
    report_q.push_back(mk_report(OP_RELATIVE, 1, 32767, 32767, 0, 0, 7, -32768, 0, 'hA5, 11));
    report_q.push_back(mk_report(OP_RELATIVE, 1, 0, 0, 0, 0, 7, 5, 1, 1, 12));
    report_q.push_back(mk_report(OP_RELATIVE, 1, 0, 0, 0, 0, 7, 32767, 0, 2, 13));
    // position equal to the cursor, left already held elsewhere
    report_q.push_back(mk_report(OP_ABSOLUTE, 2, 0, 0, 1023, 767, 1, 0, 0, 3, 14));
    report_q.push_back(mk_report(OP_ABSOLUTE, 2, 0, 0, 65535, 65535, 1, 100, 0, 4, 15));
    report_q.push_back(mk_report(OP_ABSOLUTE, 3, 0, 0, 0, 0, 4, 0, 0, 5, 16));
    report_q.push_back(mk_report(OP_RELEASE, 1, 9, 9, 9, 9, 7, 7, 0, 6, 17));
    report_q.push_back(mk_report(OP_RELEASE, 2, 0, 0, 0, 0, 0, 0, 0, 7, 18));
    report_q.push_back(mk_report(OP_UNUSED, 0, 5, 5, 5, 5, 7, 3, 0, 8, 19));
    report_q.push_back(mk_report(OP_RELEASE, 3, 0, 0, 0, 0, 0, 0, 0, 9, 20));
    report_q.push_back(mk_report(OP_RELATIVE, 2, -1, 1, 0, 0, 6, 0, 0, 0, 0));
    report_q.push_back(mk_report(OP_ABSOLUTE, 0, 0, 0, 3000, 100, 6, 0, 0, 'h80, 21));
    report_q.push_back(mk_report(OP_RELEASE, 2, 0, 0, 0, 0, 7, 0, 0, 'h40, 22));
    report_q.push_back(mk_report(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0, 'h20, 23));
    settle();

    // shrink the screen below the cursor; zero and oversize act as limits
    write_reg(CFG_WIDTH, 13'd0);
    write_reg(CFG_HEIGHT, 13'd8191);
    report_q.push_back(mk_report(OP_RELATIVE, 1, 0, 0, 0, 0, 2, 0, 0, 'h11, 30));
    report_q.push_back(mk_report(OP_RELATIVE, 1, 0, 1, 0, 0, 2, 0, 0, 'h12, 31));
    report_q.push_back(mk_report(OP_ABSOLUTE, 1, 0, 0, 0, 5000, 0, 0, 0, 'h13, 32));
    settle();
    write_reg(CFG_WIDTH, 13'd4096);
    write_reg(CFG_HEIGHT, 13'd1);
    report_q.push_back(mk_report(OP_RELATIVE, 0, 32767, -1, 0, 0, 0, 1, 0, 'h14, 33));
    report_q.push_back(mk_report(OP_ABSOLUTE, 0, 0, 0, 4095, 0, 0, 0, 0, 'h15, 34));
    settle();

    steady_tx = 1'b0;
    for (p = 0; p < 7; p++) begin
      case (p)
        0: begin w = 1024; h = 768; end
        1: begin w = 1; h = 4096; end
        2: begin w = 4096; h = 1; end
        3: begin w = 0; h = 8191; end
        4: begin w = 8191; h = 0; end
        default: begin
          w = $urandom_range(1, 4096);
          h = $urandom_range(1, 4096);
        end
      endcase
      write_reg(CFG_WIDTH, 13'(w));
      write_reg(CFG_HEIGHT, 13'(h));
      steady_tx = (p == 2 || p == 4);
      steady_rx = (p == 2);
      // back-to-back reports against a stalled receiver fill the plan queue
      if (p == 4) hold_req = 1'b1;
      for (int i = 0; i < 10; i++)
        report_q.push_back(rand_report(eff_size(width_sh), eff_size(height_sh)));
      settle();
    end

    steady_tx = 1'b0;
    steady_rx = 1'b0;
    write_reg(CFG_ENABLE, 13'd0);
    for (int i = 0; i < 8; i++)
      report_q.push_back(rand_report(eff_size(width_sh), eff_size(height_sh)));
    settle();
    write_reg(CFG_ENABLE, 13'd1);
    write_reg(CFG_WIDTH, 13'd1024);
    write_reg(CFG_HEIGHT, 13'd768);
    for (int i = 0; i < 8; i++)
      report_q.push_back(rand_report(eff_size(width_sh), eff_size(height_sh)));
    settle();

    if (err_cnt == 0 && event_q.size() == 0) begin
      $display("[pointer_event_synthesizer_core] OK");
    end else begin
      $display("[pointer_event_synthesizer_core] ERROR");
    end
    $finish;
  end

endmodule
